@@ src/xthid_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xthid_pkg
// Shared types and constants for the XT scan code to HID boot report block.
// ----------------------------------------------------------------------------
package xthid_pkg;

  localparam int CODE_W    = 7;   // scan code and modifier code width
  localparam int CFG_IDX_W = 3;   // configuration register index width
  localparam int NUM_MODS  = 5;
  localparam int SLOT_COUNT = 6;  // key slots in a boot report
  localparam int RELEASE_BIT = 7; // break flag in the raw XT byte

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_SHIFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SHIFT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_CTRL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_ALT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GUI         = 3'd4;

  // input operation codes
  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  // HID modifier bit for each register, in register order
  localparam logic [7:0] MOD_BITS [NUM_MODS] = '{8'h02, 8'h20, 8'h01, 8'h04, 8'h08};
  localparam logic [CODE_W-1:0] MOD_RESETS [NUM_MODS] =
    '{7'd42, 7'd54, 7'd29, 7'd56, 7'd58};

  typedef struct packed {
    logic       func;
    logic [7:0] key_byte;
    logic [6:0] map_index;
    logic [7:0] map_code;
  } key_item_t;

  typedef struct packed {
    logic [7:0] modifier_byte;
    logic [7:0] slot0;
    logic [7:0] slot1;
    logic [7:0] slot2;
    logic [7:0] slot3;
    logic [7:0] slot4;
    logic [7:0] slot5;
  } report_item_t;

  // scanner to control status
  typedef struct packed {
    logic rd_en;  // usage table read issued this cycle
    logic done;   // walk finishes this cycle
  } scan_status_t;

endpackage
`default_nettype wire

@@ src/xthid_usage_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xthid_usage_ram
// Usage code table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module xthid_usage_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ src/xthid_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xthid_scan
// Walks the key-down bitmap one byte group at a time, lowest code first,
// and issues one usage table read per down key until the report is full or the last group is done.
// ----------------------------------------------------------------------------
module xthid_scan #(
  parameter int SCAN_CODES  = 128,
  parameter int REPORT_KEYS = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [SCAN_CODES-1:0]         key_map,
  output logic      [$clog2(SCAN_CODES)-1:0] rd_addr,
  output xthid_pkg::scan_status_t            status
);

  localparam int GROUPS = (SCAN_CODES + 7) / 8;
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int MAP_W  = GROUPS * 8;
  localparam int IDX_W  = $clog2(SCAN_CODES);
  localparam int CNT_W  = $clog2(REPORT_KEYS + 1);

  logic             active;
  logic             load;   // rem must be reloaded from the bitmap
  logic [GRP_W-1:0] grp;
  logic [7:0]       rem;
  logic [CNT_W-1:0] fill;

  logic [MAP_W-1:0]   map_pad;
  logic [7:0]         chunk;
  logic [7:0]         cur;
  logic [7:0]         rest;
  logic [2:0]         pos;
  logic               hit;
  logic               adv;
  logic               last;
  logic               full;
  logic [GRP_W+2:0]   addr_full;

  assign map_pad = MAP_W'(key_map);
  assign chunk   = map_pad[{grp, 3'b000} +: 8];

  always_comb begin
    // code zero never fills a slot
    cur = load ? (chunk & ((grp == '0) ? 8'hFE : 8'hFF)) : rem;
    pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (cur[i]) begin
        pos = 3'(i);
      end
    end
  end

  assign hit       = |cur;
  assign rest      = cur & ~(8'h01 << pos);
  assign adv       = !hit || (rest == 8'h00);
  assign last      = (grp == GRP_W'(GROUPS - 1));
  assign full      = hit && (fill == CNT_W'(REPORT_KEYS - 1));
  assign addr_full = {grp, pos};
  assign rd_addr   = addr_full[IDX_W-1:0];

  assign status.rd_en = active && hit;
  assign status.done  = active && (full || (adv && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      load   <= 1'b1;
      grp    <= '0;
      fill   <= '0;
    end else if (start) begin
      active <= 1'b1;
      load   <= 1'b1;
      grp    <= '0;
      fill   <= '0;
    end else if (active) begin
      if (hit) begin
        fill <= CNT_W'(fill + 1'b1);
      end
      if (adv) begin
        grp  <= GRP_W'(grp + 1'b1);
        load <= 1'b1;
      end else begin
        load <= 1'b0;
      end
      if (status.done) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active && !adv) begin
      rem <= rest;
    end
  end

endmodule
`default_nettype wire

@@ src/xt_scancode_to_hid_report.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xt_scancode_to_hid_report
// XT keyboard bytes in, HID boot keyboard reports out. Modifier codes update
// the modifier byte; other codes update a key-down bitmap, and the six key
// slots are rebuilt from the usage table for the lowest down codes.
//
//   channel  dir  handshake          payload
//   key      in   key_valid/stall    xthid_pkg::key_item_t
//   rpt      out  rpt_valid/stall    xthid_pkg::report_item_t
//   cfg      in   cfg_we             cfg_index, cfg_data
//
// Table load: no report. Modifier key: the modifier byte is updated and the
// report is raised from ST_EMIT. Other keys: the walk in ST_SCAN visits byte
// groups in turn, up to the one that fills the last slot or the last group,
// with an extra step per extra down key in a group; then ST_DRAIN, ST_EMIT.
// The usage table holds garbage until loaded.
// A new item is taken while a report waits on rpt_stall; the next one waits.
// ----------------------------------------------------------------------------
module xt_scancode_to_hid_report #(
  parameter int SCAN_CODES  = 128,
  parameter int REPORT_KEYS = 6
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 key_valid,
  output logic                                      key_stall,
  input  wire xthid_pkg::key_item_t                 key_item,
  output logic                                      rpt_valid,
  input  wire logic                                 rpt_stall,
  output xthid_pkg::report_item_t                   rpt_item,
  input  wire logic                                 cfg_we,
  input  wire logic [xthid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [xthid_pkg::CODE_W-1:0]         cfg_data
);

  localparam int IDX_W  = $clog2(SCAN_CODES);
  localparam int SLOT_W = (REPORT_KEYS > 1) ? $clog2(REPORT_KEYS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t state;

  logic [xthid_pkg::CODE_W-1:0] mod_codes [xthid_pkg::NUM_MODS];
  logic [SCAN_CODES-1:0]        key_map;
  logic [7:0]                   mod_state;
  logic [7:0]                   slots [REPORT_KEYS];
  logic [SLOT_W-1:0]            wr_ptr;
  logic                         rd_pend;

  logic                         key_acc;
  logic [6:0]                   scan;
  logic                         press;
  logic                         in_range;
  logic                         mod_hit;
  logic [7:0]                   mod_bit;
  logic                         key_start;
  logic                         ram_we;
  logic [7:0]                   ram_q;
  logic [IDX_W-1:0]             rd_addr;
  xthid_pkg::scan_status_t      scan_st;
  logic [7:0]                   rpt_slots [xthid_pkg::SLOT_COUNT];

  assign key_stall = (state != ST_IDLE);
  assign key_acc   = key_valid && !key_stall;
  assign scan      = key_item.key_byte[6:0];
  assign press     = !key_item.key_byte[xthid_pkg::RELEASE_BIT];
  assign in_range  = ({1'b0, scan} < 8'(SCAN_CODES));

  // first matching register wins
  always_comb begin
    mod_hit = 1'b0;
    mod_bit = 8'h00;
    for (int m = xthid_pkg::NUM_MODS - 1; m >= 0; m--) begin
      if (mod_codes[m] == scan) begin
        mod_hit = 1'b1;
        mod_bit = xthid_pkg::MOD_BITS[m];
      end
    end
  end

  assign key_start = key_acc && (key_item.func == xthid_pkg::FUNC_KEY) && !mod_hit;
  assign ram_we    = key_acc && (key_item.func == xthid_pkg::FUNC_LOAD) &&
                     ({1'b0, key_item.map_index} < 8'(SCAN_CODES));

  xthid_usage_ram #(
    .DEPTH (SCAN_CODES),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (key_item.map_index[IDX_W-1:0]),
    .wdata (key_item.map_code),
    .re    (scan_st.rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  xthid_scan #(
    .SCAN_CODES  (SCAN_CODES),
    .REPORT_KEYS (REPORT_KEYS)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (key_start),
    .key_map (key_map),
    .rd_addr (rd_addr),
    .status  (scan_st)
  );

  for (genvar j = 0; j < xthid_pkg::SLOT_COUNT; j++) begin : g_slot
    if (j < REPORT_KEYS) begin : g_used
      assign rpt_slots[j] = slots[j];
    end else begin : g_zero
      assign rpt_slots[j] = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rpt_valid <= 1'b0;
      key_map   <= '0;
      mod_state <= 8'h00;
      rd_pend   <= 1'b0;
      wr_ptr    <= '0;
      for (int m = 0; m < xthid_pkg::NUM_MODS; m++) begin
        mod_codes[m] <= xthid_pkg::MOD_RESETS[m];
      end
      for (int j = 0; j < REPORT_KEYS; j++) begin
        slots[j] <= 8'h00;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          xthid_pkg::REG_LEFT_SHIFT:  mod_codes[0] <= cfg_data;
          xthid_pkg::REG_RIGHT_SHIFT: mod_codes[1] <= cfg_data;
          xthid_pkg::REG_LEFT_CTRL:   mod_codes[2] <= cfg_data;
          xthid_pkg::REG_LEFT_ALT:    mod_codes[3] <= cfg_data;
          xthid_pkg::REG_GUI:         mod_codes[4] <= cfg_data;
          default: ;
        endcase
      end

      if (rpt_valid && !rpt_stall) begin
        rpt_valid <= 1'b0;
      end

      // usage read data lands in the cycle after issue
      rd_pend <= scan_st.rd_en;
      if (rd_pend) begin
        slots[wr_ptr] <= ram_q;
        wr_ptr        <= SLOT_W'(wr_ptr + 1'b1);
      end

      unique case (state)
        ST_IDLE: begin
          if (key_acc && (key_item.func == xthid_pkg::FUNC_KEY)) begin
            if (mod_hit) begin
              mod_state <= press ? (mod_state | mod_bit) : (mod_state & ~mod_bit);
              state     <= ST_EMIT;
            end else begin
              if (in_range) begin
                key_map[scan[IDX_W-1:0]] <= press;
              end
              for (int j = 0; j < REPORT_KEYS; j++) begin
                slots[j] <= 8'h00;
              end
              wr_ptr <= '0;
              state  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_st.done) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!rpt_valid || !rpt_stall) begin
            rpt_valid              <= 1'b1;
            rpt_item.modifier_byte <= mod_state;
            rpt_item.slot0         <= rpt_slots[0];
            rpt_item.slot1         <= rpt_slots[1];
            rpt_item.slot2         <= rpt_slots[2];
            rpt_item.slot3         <= rpt_slots[3];
            rpt_item.slot4         <= rpt_slots[4];
            rpt_item.slot5         <= rpt_slots[5];
            state                  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/xthid_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xthid_checker
// Port-level checks for the scan code to HID report block.
// ----------------------------------------------------------------------------
module xthid_checker (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    key_valid,
  input wire logic                    key_stall,
  input wire xthid_pkg::key_item_t    key_item,
  input wire logic                    rpt_valid,
  input wire logic                    rpt_stall,
  input wire xthid_pkg::report_item_t rpt_item
);

  // a stalled report holds
  a_rpt_hold: assert property (@(posedge clk) disable iff (rst)
    rpt_valid && rpt_stall |=> rpt_valid && $stable(rpt_item))
    else $error("report changed while stalled");

  // a table load with no report pending never raises a report
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    key_valid && !key_stall && (key_item.func == xthid_pkg::FUNC_LOAD) && !rpt_valid
    |=> !rpt_valid)
    else $error("report after table load");

  // an accepted key item closes the input as its report build begins
  a_key_busy: assert property (@(posedge clk) disable iff (rst)
    key_valid && !key_stall && (key_item.func == xthid_pkg::FUNC_KEY) |=> key_stall)
    else $error("key item followed by open input");

  // only defined modifier bits are ever set
  a_mod_bits: assert property (@(posedge clk) disable iff (rst)
    rpt_valid |-> (rpt_item.modifier_byte[7:6] == 2'b00) &&
                  (rpt_item.modifier_byte[4] == 1'b0))
    else $error("undefined modifier bit set");

endmodule

bind xt_scancode_to_hid_report xthid_checker u_xthid_checker (
  .clk       (clk),
  .rst       (rst),
  .key_valid (key_valid),
  .key_stall (key_stall),
  .key_item  (key_item),
  .rpt_valid (rpt_valid),
  .rpt_stall (rpt_stall),
  .rpt_item  (rpt_item)
);
`default_nettype wire
